@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the copy request guard checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CRG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("copy request guard assertion failed");

// Next-cycle implication, disabled while reset is low.
`define CRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("copy request guard assertion failed");

`endif

@@ rtl/crg_pkg.sv @@
// ---------------------------------------------------------------------------
// crg_pkg
// Types, codes and constants of the copy request guard.
// ---------------------------------------------------------------------------
package crg_pkg;

    localparam int ALIGN_BITS = 20;
    localparam int WORD_W     = 32;
    localparam int ADDR_W     = 5;

    localparam int S_TDATA_W  = 128;
    localparam int M_TDATA_W  = 232;
    localparam int M_TUSER_W  = 3;

    typedef enum logic [1:0] {
        VERDICT_POLL    = 2'd0,
        VERDICT_START   = 2'd1,
        VERDICT_REFUSED = 2'd2
    } t_verdict;

    typedef enum logic [3:0] {
        REASON_NONE        = 4'd0,
        REASON_SIZE_ZERO   = 4'd1,
        REASON_DST_LOW     = 4'd2,
        REASON_ARENA_SIZE  = 4'd3,
        REASON_DST_HIGH    = 4'd4,
        REASON_DST_WRAP    = 4'd5,
        REASON_SRC_LOW     = 4'd6,
        REASON_STAGE_SIZE  = 4'd7,
        REASON_SRC_HIGH    = 4'd8,
        REASON_SRC_WRAP    = 4'd9,
        REASON_LIMIT_FLOOR = 4'd10,
        REASON_LIMIT_CEIL  = 4'd11,
        REASON_LIMIT_ALIGN = 4'd12,
        REASON_DST_HEAP    = 4'd13,
        REASON_HEAP_ROOM   = 4'd14
    } t_reason;

    typedef enum logic [2:0] {
        REG_DDR_FLOOR     = 3'd0,
        REG_HEAP_CEILING  = 3'd1,
        REG_ARENA_START   = 3'd2,
        REG_ARENA_STOP    = 3'd3,
        REG_STAGING_START = 3'd4,
        REG_STAGING_SPAN  = 3'd5,
        REG_HEAP_LIMIT    = 3'd6
    } t_reg_idx;

endpackage

@@ rtl/copy_request_guard_unit.sv @@
// An input transfer is captured in the input register and then in the result
// register, which drives m_axis_tvalid.
// Throughput: one poll per cycle while m_axis_tready does not stall; the input register and the result register
// let a new poll enter while a finished result waits for m_axis_tready.
// Reset (synchronous, active low) clears the configuration registers, the
// sequence, error, start and total state, and both valid flags.
// ---------------------------------------------------------------------------
// copy_request_guard_unit
// Bounds checks host copy requests from a mailbox and issues copy commands.
// ---------------------------------------------------------------------------
module copy_request_guard_unit
    import crg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [WORD_W-1:0]    pwdata,
    output logic [WORD_W-1:0]    prdata,
    output logic                 pready,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // req_seq[31:0], src_addr[63:32], dst_addr[95:64], byte_len[127:96]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // func[0]
    input  logic                 s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // copy_src[31:0], copy_dst[63:32], copy_len[95:64], refuse_code[99:96],
    // refuse_addr[131:100], ack_seq[163:132], request_total[195:164],
    // byte_total[227:196], zero pad[231:228]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // verdict[1:0], copy_go[2]
    output logic [M_TUSER_W-1:0] m_axis_tuser
);

    logic [WORD_W-1:0] r_ddr_floor, r_heap_ceiling, r_arena_start, r_arena_stop;
    logic [WORD_W-1:0] r_staging_start, r_staging_span, r_heap_limit;

    logic              r_in_valid;
    logic              r_in_func;
    logic [WORD_W-1:0] r_in_seq, r_in_src, r_in_dst, r_in_len;

    logic              r_out_valid;
    logic [M_TDATA_W-1:0] r_out_tdata;
    logic [M_TUSER_W-1:0] r_out_tuser;

    logic              r_start, r_error;
    logic [WORD_W-1:0] r_last_seq, r_fault_addr, r_count, r_bytes;
    t_reason           r_reason;

    logic              n_start, n_error;
    logic [WORD_W-1:0] n_last_seq, n_fault_addr, n_count, n_bytes;
    t_reason           n_reason;
    t_verdict          n_verdict;
    logic              n_go;
    logic [WORD_W-1:0] n_copy_src, n_copy_dst, n_copy_len;

    logic              cfg_write;
    t_reg_idx          cfg_idx;
    logic              advance;

    logic [WORD_W-1:0] arena_gap, arena_top, stage_top, heap_room;
    logic [WORD_W:0]   dst_sum, src_sum;
    t_reason           why;

    assign pready    = 1'b1;
    assign cfg_idx   = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_DDR_FLOOR:     prdata = r_ddr_floor;
            REG_HEAP_CEILING:  prdata = r_heap_ceiling;
            REG_ARENA_START:   prdata = r_arena_start;
            REG_ARENA_STOP:    prdata = r_arena_stop;
            REG_STAGING_START: prdata = r_staging_start;
            REG_STAGING_SPAN:  prdata = r_staging_span;
            REG_HEAP_LIMIT:    prdata = r_heap_limit;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ddr_floor     <= '0;
            r_heap_ceiling  <= '0;
            r_arena_start   <= '0;
            r_arena_stop    <= '0;
            r_staging_start <= '0;
            r_staging_span  <= '0;
            r_heap_limit    <= '0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_DDR_FLOOR:     r_ddr_floor     <= pwdata;
                REG_HEAP_CEILING:  r_heap_ceiling  <= pwdata;
                REG_ARENA_START:   r_arena_start   <= pwdata;
                REG_ARENA_STOP:    r_arena_stop    <= pwdata;
                REG_STAGING_START: r_staging_start <= pwdata;
                REG_STAGING_SPAN:  r_staging_span  <= pwdata;
                REG_HEAP_LIMIT:    r_heap_limit    <= pwdata;
                default: ;
            endcase
        end
    end

    // Advance the held poll into the result register when that slot frees.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_func <= s_axis_tuser;
            r_in_seq  <= s_axis_tdata[31:0];
            r_in_src  <= s_axis_tdata[63:32];
            r_in_dst  <= s_axis_tdata[95:64];
            r_in_len  <= s_axis_tdata[127:96];
        end
    end

    assign arena_gap = r_arena_stop - r_arena_start;
    assign arena_top = r_arena_stop - r_in_len;
    assign stage_top = r_staging_start + r_staging_span - r_in_len;
    assign heap_room = r_heap_limit - r_in_dst;
    assign dst_sum   = {1'b0, r_in_dst} + {1'b0, r_in_len};
    assign src_sum   = {1'b0, r_in_src} + {1'b0, r_in_len};

    always_comb begin
        if (r_heap_limit < r_ddr_floor) begin
            why = REASON_LIMIT_FLOOR;
        end else if (r_heap_limit > r_heap_ceiling) begin
            why = REASON_LIMIT_CEIL;
        end else if (r_heap_limit[ALIGN_BITS-1:0] != '0) begin
            why = REASON_LIMIT_ALIGN;
        end else if (r_in_len == '0) begin
            why = REASON_SIZE_ZERO;
        end else if (r_in_dst < r_arena_start) begin
            why = REASON_DST_LOW;
        end else if (r_in_len > arena_gap) begin
            why = REASON_ARENA_SIZE;
        end else if (r_in_dst > arena_top) begin
            why = REASON_DST_HIGH;
        end else if (dst_sum[WORD_W]) begin
            why = REASON_DST_WRAP;
        end else if (r_in_src < r_staging_start) begin
            why = REASON_SRC_LOW;
        end else if (r_in_len > r_staging_span) begin
            why = REASON_STAGE_SIZE;
        end else if (r_in_src > stage_top) begin
            why = REASON_SRC_HIGH;
        end else if (src_sum[WORD_W]) begin
            why = REASON_SRC_WRAP;
        end else if (r_in_dst >= r_heap_limit) begin
            why = REASON_DST_HEAP;
        end else if (r_in_len > heap_room) begin
            why = REASON_HEAP_ROOM;
        end else begin
            why = REASON_NONE;
        end
    end

    always_comb begin
        n_start      = r_start || r_in_func;
        n_error      = r_error;
        n_last_seq   = r_last_seq;
        n_fault_addr = r_fault_addr;
        n_reason     = r_reason;
        n_count      = r_count;
        n_bytes      = r_bytes;
        n_verdict    = VERDICT_POLL;
        n_go         = 1'b0;
        n_copy_src   = '0;
        n_copy_dst   = '0;
        n_copy_len   = '0;
        if (n_start) begin
            n_verdict = VERDICT_START;
        end else if (r_error) begin
            n_verdict = VERDICT_REFUSED;
        end else if (r_in_seq != r_last_seq) begin
            if (why != REASON_NONE) begin
                n_fault_addr = r_in_dst;
                n_reason     = why;
                n_error      = 1'b1;
                n_verdict    = VERDICT_REFUSED;
            end else begin
                n_go       = 1'b1;
                n_copy_src = r_in_src;
                n_copy_dst = r_in_dst;
                n_copy_len = r_in_len;
                n_last_seq = r_in_seq;
                n_count    = r_count + WORD_W'(1);
                n_bytes    = r_bytes + r_in_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start      <= 1'b0;
            r_error      <= 1'b0;
            r_last_seq   <= '0;
            r_fault_addr <= '0;
            r_reason     <= REASON_NONE;
            r_count      <= '0;
            r_bytes      <= '0;
        end else if (advance) begin
            r_start      <= n_start;
            r_error      <= n_error;
            r_last_seq   <= n_last_seq;
            r_fault_addr <= n_fault_addr;
            r_reason     <= n_reason;
            r_count      <= n_count;
            r_bytes      <= n_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_tdata <= {4'b0000, n_bytes, n_count, n_last_seq, n_fault_addr,
                            n_reason, n_copy_len, n_copy_dst, n_copy_src};
            r_out_tuser <= {n_go, n_verdict};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

endmodule

@@ rtl/crg_checker.sv @@
// ---------------------------------------------------------------------------
// crg_checker
// Port-level assertions for the copy request guard, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module crg_checker
    import crg_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser
);

    // A stalled result transfer holds its payload.
    `CRG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // An issued copy only comes with a keep-polling verdict.
    `CRG_ASSERT_NOW(a_go_polls, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == VERDICT_POLL)

    // A refusal always carries a latched reason.
    `CRG_ASSERT_NOW(a_refuse_code, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser[1:0] == VERDICT_REFUSED), m_axis_tdata[99:96] != REASON_NONE)

    // Without an issued copy the command fields are zero.
    `CRG_ASSERT_NOW(a_idle_copy, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[2], m_axis_tdata[95:0] == '0)

endmodule

bind copy_request_guard_unit crg_checker u_crg_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives mailbox polls into the copy request guard over the stream slave
// port, programs the heap, arena and staging window registers over APB, and
// checks every result transfer against a cycle-free model of the guard.
// ---------------------------------------------------------------------------
module tb_top;
    import crg_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic        func;
        logic [31:0] seq;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] len;
    } t_copy_poll;

    typedef struct packed {
        t_verdict    verdict;
        logic        go;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] len;
        t_reason     code;
        logic [31:0] fault;
        logic [31:0] ack;
        logic [31:0] count;
        logic [31:0] bytes;
    } t_guard_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [WORD_W-1:0]    pwdata = '0;
    logic [WORD_W-1:0]    prdata;
    logic                 pready;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // req_seq, src_addr, dst_addr, byte_len
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // func
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // copy_src, copy_dst, copy_len, refuse_code, refuse_addr, ack_seq,
    // request_total, byte_total, zero pad
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // verdict, copy_go
    logic [M_TUSER_W-1:0] m_axis_tuser;

    logic [31:0]   guard_regs [0:6];
    logic [31:0]   seq_acked = '0;
    logic          error_flag = 1'b0;
    logic          start_flag = 1'b0;
    t_reason       reason_held = REASON_NONE;
    logic [31:0]   fault_dst = '0;
    logic [31:0]   copies_done = '0;
    logic [31:0]   bytes_done = '0;

    t_guard_answer expected_answers [$];
    int            failures = 0;
    int unsigned   cycle_count = 0;
    int            sender_gap_pct = 0;
    int            sink_stall_pct = 0;

    copy_request_guard_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < 7; i++) begin
            guard_regs[i] = '0;
        end
    end

    function automatic t_reason first_failed_check(logic [31:0] src, logic [31:0] dst,
                                                   logic [31:0] sz);
        logic [31:0] amask;
        logic [31:0] a_lo;
        logic [31:0] a_hi;
        logic [31:0] s_lo;
        logic [31:0] s_n;
        logic [31:0] lim;
        logic [31:0] tmp;
        amask = (32'd1 << ALIGN_BITS) - 32'd1;
        a_lo = guard_regs[REG_ARENA_START];
        a_hi = guard_regs[REG_ARENA_STOP];
        s_lo = guard_regs[REG_STAGING_START];
        s_n = guard_regs[REG_STAGING_SPAN];
        lim = guard_regs[REG_HEAP_LIMIT];
        if (lim < guard_regs[REG_DDR_FLOOR]) return REASON_LIMIT_FLOOR;
        if (lim > guard_regs[REG_HEAP_CEILING]) return REASON_LIMIT_CEIL;
        if ((lim & amask) != 0) return REASON_LIMIT_ALIGN;
        if (sz == 0) return REASON_SIZE_ZERO;
        if (dst < a_lo) return REASON_DST_LOW;
        tmp = a_hi - a_lo;
        if (sz > tmp) return REASON_ARENA_SIZE;
        tmp = a_hi - sz;
        if (dst > tmp) return REASON_DST_HIGH;
        tmp = dst + sz;
        if (tmp < dst) return REASON_DST_WRAP;
        if (src < s_lo) return REASON_SRC_LOW;
        if (sz > s_n) return REASON_STAGE_SIZE;
        tmp = s_lo + s_n - sz;
        if (src > tmp) return REASON_SRC_HIGH;
        tmp = src + sz;
        if (tmp < src) return REASON_SRC_WRAP;
        if (dst >= lim) return REASON_DST_HEAP;
        tmp = lim - dst;
        if (sz > tmp) return REASON_HEAP_ROOM;
        return REASON_NONE;
    endfunction

    function automatic t_guard_answer judge_poll(t_copy_poll p);
        t_guard_answer ans;
        t_reason       why;
        ans = '0;
        if (p.func) start_flag = 1'b1;
        if (start_flag) begin
            ans.verdict = VERDICT_START;
        end else if (error_flag) begin
            ans.verdict = VERDICT_REFUSED;
        end else if (p.seq != seq_acked) begin
            why = first_failed_check(p.src, p.dst, p.len);
            if (why != REASON_NONE) begin
                fault_dst = p.dst;
                reason_held = why;
                error_flag = 1'b1;
                ans.verdict = VERDICT_REFUSED;
            end else begin
                ans.go = 1'b1;
                ans.src = p.src;
                ans.dst = p.dst;
                ans.len = p.len;
                seq_acked = p.seq;
                copies_done = copies_done + 32'd1;
                bytes_done = bytes_done + p.len;
            end
        end
        ans.code = reason_held;
        ans.fault = fault_dst;
        ans.ack = seq_acked;
        ans.count = copies_done;
        ans.bytes = bytes_done;
        return ans;
    endfunction

    function automatic logic [31:0] fresh_seq();
        logic [31:0] s;
        s = $urandom;
        if (s == seq_acked) s = ~s;
        return s;
    endfunction

    function automatic t_copy_poll make_poll(logic func, logic [31:0] seq, logic [31:0] src,
                                             logic [31:0] dst, logic [31:0] len);
        t_copy_poll p;
        p.func = func;
        p.seq = seq;
        p.src = src;
        p.dst = dst;
        p.len = len;
        return p;
    endfunction

    // Build a request that passes every check under a well-ordered window setup.
    function automatic t_copy_poll compose_copy();
        logic [31:0] top;
        logic [31:0] room;
        logic [31:0] s_lo;
        logic [31:0] s_n;
        t_copy_poll  p;
        s_lo = guard_regs[REG_STAGING_START];
        s_n = guard_regs[REG_STAGING_SPAN];
        top = (guard_regs[REG_ARENA_STOP] < guard_regs[REG_HEAP_LIMIT]) ?
              guard_regs[REG_ARENA_STOP] : guard_regs[REG_HEAP_LIMIT];
        p.func = 1'b0;
        p.seq = fresh_seq();
        p.dst = $urandom_range(top - 32'd1, guard_regs[REG_ARENA_START]);
        room = top - p.dst;
        if (room > s_n) room = s_n;
        if ($urandom_range(1, 0) == 1) begin
            p.len = $urandom_range(room, 1);
        end else begin
            p.len = $urandom_range((room > 32'd64) ? 32'd64 : room, 1);
        end
        if ($urandom_range(7, 0) == 0) p.dst = top - p.len;
        if ($urandom_range(7, 0) == 0) begin
            p.src = s_lo + s_n - p.len;
        end else begin
            p.src = $urandom_range(s_lo + s_n - p.len, s_lo);
        end
        return p;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        guard_regs[idx] = value;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            $error("readback %s: expected %0h, got %0h", idx.name(), value, prdata);
            failures++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_window(input logic [31:0] floor_v, input logic [31:0] ceil_v,
                               input logic [31:0] a_lo, input logic [31:0] a_hi,
                               input logic [31:0] s_lo, input logic [31:0] s_n,
                               input logic [31:0] lim);
        write_reg(REG_DDR_FLOOR, floor_v);
        write_reg(REG_HEAP_CEILING, ceil_v);
        write_reg(REG_ARENA_START, a_lo);
        write_reg(REG_ARENA_STOP, a_hi);
        write_reg(REG_STAGING_START, s_lo);
        write_reg(REG_STAGING_SPAN, s_n);
        write_reg(REG_HEAP_LIMIT, lim);
    endtask

    task automatic send_poll(input t_copy_poll p);
        while ($urandom_range(99, 0) < sender_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {p.len, p.dst, p.src, p.seq};
        s_axis_tuser <= p.func;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_answers.push_back(judge_poll(p));
        @(negedge i_clk);
    endtask

    // Hold the input idle until every outstanding result has been taken.
    task automatic settle_traffic();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (expected_answers.size() != 0);
    endtask

    task automatic run_copy_traffic(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9, 0) == 0) begin
                send_poll(make_poll(1'b0, seq_acked, $urandom, $urandom, $urandom));
            end else begin
                send_poll(compose_copy());
                sent++;
            end
        end
    endtask

    task automatic test_reset_and_extremes();
        send_poll(make_poll(1'b0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        settle_traffic();
        load_window(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                    32'hFFF0_0000);
        send_poll(make_poll(1'b0, 32'h0, 32'h1234_5678, 32'h0, 32'h0));
        send_poll(make_poll(1'b0, 32'h1, 32'h0, 32'h0, 32'h1));
        send_poll(make_poll(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFEF_FFFF, 32'h1));
        send_poll(make_poll(1'b0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0));
        send_poll(make_poll(1'b0, 32'h0, 32'h0, 32'h0, 32'hFFF0_0000));
        send_poll(make_poll(1'b0, 32'h5555_5555, 32'h000F_FFFF, 32'h0, 32'hFFF0_0000));
        send_poll(make_poll(1'b0, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'h2AAA_AAAA));
        settle_traffic();
        load_window(32'h4000_0000, 32'h4000_0000, 32'h3000_0000, 32'h4000_0000,
                    32'hF000_0000, 32'h0FFF_FFFF, 32'h4000_0000);
        send_poll(make_poll(1'b0, 32'h2, 32'hF000_0000, 32'h3000_0000, 32'h0FFF_FFFF));
        send_poll(make_poll(1'b0, 32'h3, 32'hFFFF_FFFE, 32'h3FFF_FFFF, 32'h1));
    endtask

    task automatic test_wide_window_traffic(input int count);
        settle_traffic();
        load_window(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                    32'hFFF0_0000);
        run_copy_traffic(count);
    endtask

    task automatic test_tight_window_traffic(input int count);
        settle_traffic();
        load_window(32'h4000_0000, 32'h4000_0000, 32'h3000_0000, 32'h4000_0000,
                    32'hF000_0000, 32'h0FFF_FFFF, 32'h4000_0000);
        run_copy_traffic(count);
    endtask

    task automatic test_random_window_traffic(input int windows, input int count);
        logic [31:0] lim;
        logic [31:0] a_lo;
        logic [31:0] a_hi;
        logic [31:0] s_lo;
        logic [31:0] s_n;
        repeat (windows) begin
            lim = {12'($urandom_range(12'hFFF, 1)), 20'h0};
            a_lo = $urandom_range(lim - 32'd1, 0);
            if ($urandom_range(1, 0) == 1) begin
                a_hi = $urandom_range(32'hFFFF_FFFF, a_lo + 32'd1);
            end else begin
                a_hi = a_lo + $urandom_range(4096, 1);
            end
            s_lo = $urandom_range(32'hFFFF_FFFE, 0);
            s_n = $urandom_range(~s_lo, 1);
            settle_traffic();
            load_window($urandom_range(lim, 0), $urandom_range(32'hFFFF_FFFF, lim),
                        a_lo, a_hi, s_lo, s_n, lim);
            run_copy_traffic(count);
        end
    endtask

    task automatic test_refusal_and_start();
        t_copy_poll base;
        t_copy_poll trip;
        t_reason    reason;
        bit         start_first;
        settle_traffic();
        load_window(32'h1000_0000, 32'hC000_0000, 32'h2000_0000, 32'hA000_0000,
                    32'hB000_0000, 32'h1000_0000, 32'h8000_0000);
        base = make_poll(1'b0, 32'h0, 32'hB000_0000, 32'h2000_0000, 32'h100);
        repeat (2) begin
            base.seq = fresh_seq();
            send_poll(base);
        end
        settle_traffic();
        reason = t_reason'($urandom_range(14, 1));
        start_first = ($urandom_range(3, 0) == 0);
        trip = base;
        trip.seq = fresh_seq();
        case (reason)
            REASON_SIZE_ZERO: trip.len = 32'h0;
            REASON_DST_LOW: trip.dst = 32'h1FFF_FFFF;
            REASON_ARENA_SIZE: trip.len = 32'h8000_0001;
            REASON_DST_HIGH: begin
                trip.dst = 32'h9FFF_FFF0;
                trip.len = 32'h20;
            end
            REASON_DST_WRAP: begin
                write_reg(REG_ARENA_START, 32'hF000_0000);
                write_reg(REG_ARENA_STOP, 32'h1000_0000);
                trip.dst = 32'hF000_0000;
                trip.len = 32'h1800_0000;
            end
            REASON_SRC_LOW: trip.src = 32'hAFFF_FFFF;
            REASON_STAGE_SIZE: trip.len = 32'h1000_0001;
            REASON_SRC_HIGH: trip.src = 32'hBFFF_FFF0;
            REASON_SRC_WRAP: begin
                write_reg(REG_STAGING_START, 32'hF000_0000);
                write_reg(REG_STAGING_SPAN, 32'h2000_0000);
                trip.src = 32'hF000_0000;
                trip.len = 32'h1800_0000;
            end
            REASON_LIMIT_FLOOR: write_reg(REG_DDR_FLOOR, 32'h9000_0000);
            REASON_LIMIT_CEIL: write_reg(REG_HEAP_CEILING, 32'h7000_0000);
            REASON_LIMIT_ALIGN: write_reg(REG_HEAP_LIMIT, 32'h8008_0000);
            REASON_DST_HEAP: trip.dst = 32'h8000_0000;
            REASON_HEAP_ROOM: trip.dst = 32'h7FFF_FFF0;
            default: ;
        endcase
        if (start_first) begin
            send_poll(make_poll(1'b1, $urandom, $urandom, $urandom, $urandom));
        end
        send_poll(trip);
        send_poll(make_poll(1'b0, seq_acked, $urandom, $urandom, $urandom));
        repeat (3) send_poll(make_poll(1'b0, fresh_seq(), $urandom, $urandom, $urandom));
        send_poll(make_poll(1'b1, $urandom, $urandom, $urandom, $urandom));
        repeat (4) begin
            send_poll(make_poll(1'($urandom_range(1, 0)), $urandom, $urandom, $urandom,
                                $urandom));
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : check_answers
        t_guard_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_answers.size() == 0) begin
                $error("result transfer with no pending poll");
                failures++;
            end else begin
                want = expected_answers.pop_front();
                compare_field("verdict", 32'(want.verdict), 32'(m_axis_tuser[1:0]));
                compare_field("copy_go", 32'(want.go), 32'(m_axis_tuser[2]));
                compare_field("copy_src", want.src, m_axis_tdata[31:0]);
                compare_field("copy_dst", want.dst, m_axis_tdata[63:32]);
                compare_field("copy_len", want.len, m_axis_tdata[95:64]);
                compare_field("refuse_code", 32'(want.code), 32'(m_axis_tdata[99:96]));
                compare_field("refuse_addr", want.fault, m_axis_tdata[131:100]);
                compare_field("ack_seq", want.ack, m_axis_tdata[163:132]);
                compare_field("request_total", want.count, m_axis_tdata[195:164]);
                compare_field("byte_total", want.bytes, m_axis_tdata[227:196]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        sender_gap_pct = 22;
        sink_stall_pct = 75;
        test_reset_and_extremes();
        test_wide_window_traffic(260);
        sender_gap_pct = 75;
        sink_stall_pct = 22;
        test_tight_window_traffic(260);
        sender_gap_pct = 0;
        sink_stall_pct = 0;
        test_random_window_traffic(4, 65);
        test_refusal_and_start();
        settle_traffic();
        repeat (8) @(negedge i_clk);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
